FILE: rtl/dswf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dswf_pkg: shared definitions for the dirty state write filter
// sizes, field widths, opcodes, controller/datapath interface structs and
// ring position helpers
// ----------------------------------------------------------------------------
package dswf_pkg;

    // table sizes
    localparam int GLOBAL_SETTINGS = 256;
    localparam int STAGE_COUNT     = 8;
    localparam int STAGE_TYPES     = 32;
    localparam int STAGE_KEYS      = STAGE_COUNT * STAGE_TYPES;

    // derived widths
    localparam int GA_W   = $clog2(GLOBAL_SETTINGS);
    localparam int SK_W   = $clog2(STAGE_KEYS);
    localparam int TYPE_W = $clog2(STAGE_TYPES);
    localparam int GP_W   = $clog2(2 * GLOBAL_SETTINGS);
    localparam int SP_W   = $clog2(2 * STAGE_KEYS);
    localparam int CLR_N  = (GLOBAL_SETTINGS > STAGE_KEYS) ? GLOBAL_SETTINGS : STAGE_KEYS;
    localparam int CLR_W  = $clog2(CLR_N);

    // request field widths
    localparam int FUNC_W  = 2;
    localparam int INDEX_W = 8;
    localparam int STAGE_W = 3;
    localparam int VALUE_W = 32;

    // stream widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    // opcodes
    localparam logic [FUNC_W-1:0] FUNC_SET_GLOBAL = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_STAGE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DRAIN      = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic clr_en;   // clearing pass step
        logic sel_in;   // read addresses from the incoming request
        logic capture;  // latch the incoming request
        logic commit;   // write tables, move pointers, load result
    } dswf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_drain;  // incoming request is a drain
        logic clr_last;  // last entry of the clearing pass
        logic out_busy;  // result register full and not being taken
    } dswf_status_t;

    // per-stage key = type * STAGE_COUNT + stage
    function automatic logic [SK_W-1:0] stage_key(input logic [TYPE_W-1:0] typ,
                                                  input logic [STAGE_W-1:0] stg);
        return SK_W'(SK_W'(typ) * SK_W'(STAGE_COUNT) + SK_W'(stg));
    endfunction

    // ring positions wrap at twice the capacity
    function automatic logic [GP_W-1:0] g_next(input logic [GP_W-1:0] pos);
        return (pos == GP_W'(2 * GLOBAL_SETTINGS - 1)) ? '0 : GP_W'(pos + 1'b1);
    endfunction

    function automatic logic [GA_W-1:0] g_slot(input logic [GP_W-1:0] pos);
        return (pos >= GP_W'(GLOBAL_SETTINGS)) ? GA_W'(pos - GP_W'(GLOBAL_SETTINGS))
                                               : GA_W'(pos);
    endfunction

    function automatic logic [SP_W-1:0] s_next(input logic [SP_W-1:0] pos);
        return (pos == SP_W'(2 * STAGE_KEYS - 1)) ? '0 : SP_W'(pos + 1'b1);
    endfunction

    function automatic logic [SK_W-1:0] s_slot(input logic [SP_W-1:0] pos);
        return (pos >= SP_W'(STAGE_KEYS)) ? SK_W'(pos - SP_W'(STAGE_KEYS)) : SK_W'(pos);
    endfunction

endpackage

FILE: rtl/dswf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dswf_ram: generic single write, single read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module dswf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/dswf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dswf_ctrl: request sequencer
// runs the clearing pass after reset, then steps each request through
// table lookup and commit
// ----------------------------------------------------------------------------
module dswf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  dswf_pkg::dswf_status_t status,
    output dswf_pkg::dswf_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_LOOK   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.sel_in = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    // drains need the list entry before the table lookup
                    state_next  = status.in_drain ? ST_LOOK : ST_FINISH;
                end
            end
            ST_LOOK: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!status.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_commit_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> state_reg == ST_IDLE)
        else $error("commit not followed by idle");

    a_drain_goes_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && status.in_drain) |=> state_reg == ST_LOOK)
        else $error("drain request skipped list lookup");

    a_clear_ends_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && status.clr_last) |=> state_reg == ST_IDLE)
        else $error("clearing pass did not end in idle");
`endif

endmodule

FILE: rtl/dswf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dswf_datapath: tables, dirty lists, ring pointers and result register
// pending entries hold a dirty flag above the value; shadows hold what the
// device last received
// ----------------------------------------------------------------------------
module dswf_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  dswf_pkg::dswf_cmd_t             cmd,
    output dswf_pkg::dswf_status_t          status,
    input  logic [dswf_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [dswf_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dswf_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [dswf_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                            m_tlast
);

    localparam int GA_W    = dswf_pkg::GA_W;
    localparam int SK_W    = dswf_pkg::SK_W;
    localparam int TYPE_W  = dswf_pkg::TYPE_W;
    localparam int GP_W    = dswf_pkg::GP_W;
    localparam int SP_W    = dswf_pkg::SP_W;
    localparam int CLR_W   = dswf_pkg::CLR_W;
    localparam int INDEX_W = dswf_pkg::INDEX_W;
    localparam int STAGE_W = dswf_pkg::STAGE_W;
    localparam int VALUE_W = dswf_pkg::VALUE_W;
    localparam int FUNC_W  = dswf_pkg::FUNC_W;
    localparam int SL_W    = TYPE_W + STAGE_W;

    // incoming request fields
    logic [FUNC_W-1:0]  in_func;
    logic [INDEX_W-1:0] in_index;
    logic [STAGE_W-1:0] in_stage;
    assign in_func  = s_tuser;
    assign in_index = s_tdata[7:0];
    assign in_stage = s_tdata[10:8];

    // captured request
    logic [FUNC_W-1:0]  func_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [STAGE_W-1:0] stage_reg;
    logic [VALUE_W-1:0] value_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg  <= in_func;
            index_reg <= in_index;
            stage_reg <= in_stage;
            value_reg <= s_tdata[42:11];
        end
    end

    // ring pointers
    logic [GP_W-1:0] g_wr_reg, g_wr_next, g_rd_reg, g_rd_next;
    logic [SP_W-1:0] s_wr_reg, s_wr_next, s_rd_reg, s_rd_next;
    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;

    // memory ports
    logic [GA_W-1:0]      g_addr, g_list_q;
    logic [SK_W-1:0]      s_addr;
    logic [SL_W-1:0]      s_list_q;
    logic [VALUE_W:0]     g_pend_q, s_pend_q, g_pend_wd, s_pend_wd;
    logic [VALUE_W-1:0]   g_shadow_q, s_shadow_q;
    logic                 g_pend_we, s_pend_we, g_shadow_we, s_shadow_we;
    logic                 g_list_we, s_list_we;
    logic [GA_W-1:0]      g_wr_addr;
    logic [SK_W-1:0]      s_wr_addr;
    logic [VALUE_W-1:0]   g_shadow_wd, s_shadow_wd;

    // decode
    logic item_drain, set_g_ok, set_s_ok, g_empty, s_empty, drain_g, drain_s;
    logic g_change, s_change, g_append, s_append, g_apply, s_apply, apply, done;
    logic clr_g, clr_s;

    assign item_drain = (func_reg == dswf_pkg::FUNC_DRAIN);
    assign set_g_ok   = (func_reg == dswf_pkg::FUNC_SET_GLOBAL)
                        && (int'(index_reg) < dswf_pkg::GLOBAL_SETTINGS);
    assign set_s_ok   = (func_reg == dswf_pkg::FUNC_SET_STAGE)
                        && (int'(index_reg) < dswf_pkg::STAGE_TYPES)
                        && (int'(stage_reg) < dswf_pkg::STAGE_COUNT);
    assign g_empty    = (g_wr_reg == g_rd_reg);
    assign s_empty    = (s_wr_reg == s_rd_reg);
    assign drain_g    = item_drain && !g_empty;
    assign drain_s    = item_drain && g_empty && !s_empty;

    // lookup address: incoming request, listed key on a drain, else captured key
    always_comb begin
        if (cmd.sel_in) begin
            g_addr = in_index[GA_W-1:0];
            s_addr = dswf_pkg::stage_key(in_index[TYPE_W-1:0], in_stage);
        end else if (item_drain) begin
            g_addr = g_list_q;
            s_addr = dswf_pkg::stage_key(s_list_q[SL_W-1:STAGE_W], s_list_q[STAGE_W-1:0]);
        end else begin
            g_addr = index_reg[GA_W-1:0];
            s_addr = dswf_pkg::stage_key(index_reg[TYPE_W-1:0], stage_reg);
        end
    end

    assign g_change = (g_pend_q[VALUE_W-1:0] != value_reg);
    assign s_change = (s_pend_q[VALUE_W-1:0] != value_reg);
    assign g_append = set_g_ok && g_change && !g_pend_q[VALUE_W];
    assign s_append = set_s_ok && s_change && !s_pend_q[VALUE_W];
    assign g_apply  = drain_g && (g_shadow_q != g_pend_q[VALUE_W-1:0]);
    assign s_apply  = drain_s && (s_shadow_q != s_pend_q[VALUE_W-1:0]);
    assign apply    = g_apply || s_apply;

    // clearing pass covers the smaller family only while in range
    assign clr_g = cmd.clr_en && (int'(clr_cnt_reg) < dswf_pkg::GLOBAL_SETTINGS);
    assign clr_s = cmd.clr_en && (int'(clr_cnt_reg) < dswf_pkg::STAGE_KEYS);

    // table writes
    always_comb begin
        g_wr_addr   = g_addr;
        s_wr_addr   = s_addr;
        g_pend_we   = 1'b0;
        s_pend_we   = 1'b0;
        g_shadow_we = 1'b0;
        s_shadow_we = 1'b0;
        g_pend_wd   = drain_g ? {1'b0, g_pend_q[VALUE_W-1:0]} : {1'b1, value_reg};
        s_pend_wd   = drain_s ? {1'b0, s_pend_q[VALUE_W-1:0]} : {1'b1, value_reg};
        g_shadow_wd = g_pend_q[VALUE_W-1:0];
        s_shadow_wd = s_pend_q[VALUE_W-1:0];
        if (cmd.clr_en) begin
            g_wr_addr   = GA_W'(clr_cnt_reg);
            s_wr_addr   = SK_W'(clr_cnt_reg);
            g_pend_we   = clr_g;
            s_pend_we   = clr_s;
            g_shadow_we = clr_g;
            s_shadow_we = clr_s;
            g_pend_wd   = '0;
            s_pend_wd   = '0;
            g_shadow_wd = '0;
            s_shadow_wd = '0;
        end else if (cmd.commit) begin
            g_pend_we   = (set_g_ok && g_change) || drain_g;
            s_pend_we   = (set_s_ok && s_change) || drain_s;
            g_shadow_we = g_apply;
            s_shadow_we = s_apply;
        end
    end

    assign g_list_we = cmd.commit && g_append;
    assign s_list_we = cmd.commit && s_append;

    // pointer updates; list reset when both lists run dry on a drain
    logic [GP_W-1:0] g_rd_adv;
    logic [SP_W-1:0] s_rd_adv;
    assign g_rd_adv = drain_g ? dswf_pkg::g_next(g_rd_reg) : g_rd_reg;
    assign s_rd_adv = drain_s ? dswf_pkg::s_next(s_rd_reg) : s_rd_reg;
    assign done     = item_drain && (g_wr_reg == g_rd_adv) && (s_wr_reg == s_rd_adv);

    always_comb begin
        g_wr_next    = g_wr_reg;
        g_rd_next    = g_rd_reg;
        s_wr_next    = s_wr_reg;
        s_rd_next    = s_rd_reg;
        clr_cnt_next = cmd.clr_en ? CLR_W'(clr_cnt_reg + 1'b1) : clr_cnt_reg;
        if (cmd.commit) begin
            if (done) begin
                g_wr_next = '0;
                g_rd_next = '0;
                s_wr_next = '0;
                s_rd_next = '0;
            end else begin
                g_wr_next = g_append ? dswf_pkg::g_next(g_wr_reg) : g_wr_reg;
                s_wr_next = s_append ? dswf_pkg::s_next(s_wr_reg) : s_wr_reg;
                g_rd_next = g_rd_adv;
                s_rd_next = s_rd_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_wr_reg    <= '0;
            g_rd_reg    <= '0;
            s_wr_reg    <= '0;
            s_rd_reg    <= '0;
            clr_cnt_reg <= '0;
        end else begin
            g_wr_reg    <= g_wr_next;
            g_rd_reg    <= g_rd_next;
            s_wr_reg    <= s_wr_next;
            s_rd_reg    <= s_rd_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // memories
    dswf_ram #(.WIDTH(VALUE_W + 1), .DEPTH(dswf_pkg::GLOBAL_SETTINGS)) u_g_pend (
        .aclk(aclk), .wr_en(g_pend_we), .wr_addr(g_wr_addr), .wr_data(g_pend_wd),
        .rd_addr(g_addr), .rd_data(g_pend_q));

    dswf_ram #(.WIDTH(VALUE_W), .DEPTH(dswf_pkg::GLOBAL_SETTINGS)) u_g_shadow (
        .aclk(aclk), .wr_en(g_shadow_we), .wr_addr(g_wr_addr), .wr_data(g_shadow_wd),
        .rd_addr(g_addr), .rd_data(g_shadow_q));

    dswf_ram #(.WIDTH(GA_W), .DEPTH(dswf_pkg::GLOBAL_SETTINGS)) u_g_list (
        .aclk(aclk), .wr_en(g_list_we), .wr_addr(dswf_pkg::g_slot(g_wr_reg)),
        .wr_data(index_reg[GA_W-1:0]),
        .rd_addr(dswf_pkg::g_slot(g_rd_reg)), .rd_data(g_list_q));

    dswf_ram #(.WIDTH(VALUE_W + 1), .DEPTH(dswf_pkg::STAGE_KEYS)) u_s_pend (
        .aclk(aclk), .wr_en(s_pend_we), .wr_addr(s_wr_addr), .wr_data(s_pend_wd),
        .rd_addr(s_addr), .rd_data(s_pend_q));

    dswf_ram #(.WIDTH(VALUE_W), .DEPTH(dswf_pkg::STAGE_KEYS)) u_s_shadow (
        .aclk(aclk), .wr_en(s_shadow_we), .wr_addr(s_wr_addr), .wr_data(s_shadow_wd),
        .rd_addr(s_addr), .rd_data(s_shadow_q));

    dswf_ram #(.WIDTH(SL_W), .DEPTH(dswf_pkg::STAGE_KEYS)) u_s_list (
        .aclk(aclk), .wr_en(s_list_we), .wr_addr(dswf_pkg::s_slot(s_wr_reg)),
        .wr_data({index_reg[TYPE_W-1:0], stage_reg}),
        .rd_addr(dswf_pkg::s_slot(s_rd_reg)), .rd_data(s_list_q));

    // result register
    localparam int M_TDATA_W_L = dswf_pkg::M_TDATA_W;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W_L-1:0] m_tdata_reg;
    logic [dswf_pkg::M_TUSER_W-1:0] m_tuser_reg;
    logic                 m_tlast_reg;
    logic [INDEX_W-1:0]   res_index;
    logic [STAGE_W-1:0]   res_stage;
    logic [VALUE_W-1:0]   res_value;

    always_comb begin
        res_index = '0;
        res_stage = '0;
        res_value = '0;
        if (g_apply) begin
            res_index = INDEX_W'(g_list_q);
            res_value = g_pend_q[VALUE_W-1:0];
        end else if (s_apply) begin
            res_index = INDEX_W'(s_list_q[SL_W-1:STAGE_W]);
            res_stage = s_list_q[STAGE_W-1:0];
            res_value = s_pend_q[VALUE_W-1:0];
        end
    end

    assign m_tvalid_next = cmd.commit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tdata_reg <= {5'b0, res_value, res_stage, res_index};
            m_tuser_reg <= {s_apply, apply};
            m_tlast_reg <= done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign status.in_drain = (in_func == dswf_pkg::FUNC_DRAIN);
    assign status.clr_last = (clr_cnt_reg == CLR_W'(dswf_pkg::CLR_N - 1));
    assign status.out_busy = m_tvalid_reg && !m_tready;

`ifndef SYNTHESIS
    a_commit_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(m_tvalid_reg && !m_tready))
        else $error("result overwritten before it was taken");

    a_commit_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid_reg)
        else $error("commit did not present a result");

    a_done_resets_lists: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && done) |=> (g_wr_reg == '0 && g_rd_reg == '0
                                  && s_wr_reg == '0 && s_rd_reg == '0))
        else $error("dirty lists not reset after drain done");
`endif

endmodule

FILE: rtl/dirty_state_write_filter_top.sv
`timescale 1ns / 1ps
// a set request is accepted in ST_IDLE and its result is registered on commit in
//   ST_FINISH; a drain request passes ST_LOOK first (list read, then table read,
//   then commit). One request at a time is in flight; the table memories have
//   registered reads, and a held result stalls the commit
// reset: aresetn synchronous active low; after reset a clearing pass over
//   max(GLOBAL_SETTINGS, STAGE_COUNT*STAGE_TYPES) entries (256) zeroes the tables
// ----------------------------------------------------------------------------
// dirty_state_write_filter_top: redundant device setting write filter
// set requests update pending values and queue dirty keys; drain requests
// pop one dirty key and issue a device write only when the value changed
// ----------------------------------------------------------------------------
module dirty_state_write_filter_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // setting_index[7:0], stage[10:8], new_value[42:11], zero fill to 48
    input  logic [dswf_pkg::S_TDATA_W-1:0] s_tdata,
    // func[1:0]
    input  logic [dswf_pkg::S_TUSER_W-1:0] s_tuser,
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // write_index[7:0], write_stage[10:8], write_value[42:11], zero fill to 48
    output logic [dswf_pkg::M_TDATA_W-1:0] m_tdata,
    // apply_write[0], write_kind[1]
    output logic [dswf_pkg::M_TUSER_W-1:0] m_tuser,
    // drain_done: both dirty lists now empty and reset
    output logic                           m_tlast
);

    // command and status between sequencer and datapath
    dswf_pkg::dswf_cmd_t    cmd;
    dswf_pkg::dswf_status_t status;

    // sequencer: clearing pass, request acceptance, commit timing
    dswf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: pending/shadow tables, dirty lists, result register
    // the result register lets a new request enter while the last result waits
    dswf_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
